@@ src/tmf_pkg.sv @@
// Package: shared constants, payload types and sequencer types for the trimmed-mean filter.
package tmf_pkg;

  // History depth per channel and its index width
  localparam int WINDOW     = 10;
  localparam int CNT_BITS   = $clog2(WINDOW);
  // Running sum width; ten 12-bit samples never wrap it
  localparam int ACC_BITS   = 16;
  // Mean of the middle eight
  localparam int TRIM_SHIFT = 3;
  // Port field width of samples and results
  localparam int FIELD_BITS = 12;

  typedef logic [FIELD_BITS-1:0] field_t;

  typedef struct packed {
    field_t open_sample;
    field_t close_sample;
    field_t current_sample;
  } in_item_t;

  typedef struct packed {
    field_t open_filtered;
    field_t close_filtered;
    field_t current_filtered;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_FINISH
  } state_t;

  // Sequencer strobes toward the history lines, the units and the output register
  typedef struct packed {
    logic shift;   // push new samples on input transfer
    logic rotate;  // circulate history one place
    logic step;    // unit consumes the history tail
    logic first;   // first entry of a pass: load instead of update
    logic load;    // capture results into the output register
  } seq_ctrl_t;

endpackage

@@ src/tmf_stream_if.sv @@
// Interface: valid/ready channel carrying one payload item per transfer.
interface tmf_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/three_channel_trimmed_mean_filter_core.sv @@
// Top level: three-channel trimmed-mean moving-window filter core.
// Each input transfer pushes one sample per channel into a ten-deep history
// (reset to zeros, so the first nine results include those zeros) and yields
// one result transfer holding, per channel, (sum - min - max) >> 3 over the ten
// stored samples. The idle state takes the item and pushes it into the history,
// the accumulate state lets each channel's compare/add unit consume the history
// entries one by one as the history circulates once, and the finish state loads
// the output register as soon as it is free. The input is not ready from the
// transfer until the sequencer is back in idle; a finished result waits in the
// output register while the next input transfer is taken. Input bits above
// SAMPLE_BITS are ignored.
module three_channel_trimmed_mean_filter_core #(
  parameter int SAMPLE_BITS = 12
) (
  input logic       clk,
  input logic       rst,
  tmf_stream_if.sink   samples,
  tmf_stream_if.source filtered
);
  import tmf_pkg::*;

  seq_ctrl_t              ctrl;
  logic                   in_ready;
  logic                   out_valid;
  out_item_t              out_data;
  logic                   out_free;
  logic [SAMPLE_BITS-1:0] open_tail;
  logic [SAMPLE_BITS-1:0] close_tail;
  logic [SAMPLE_BITS-1:0] current_tail;
  field_t                 open_res;
  field_t                 close_res;
  field_t                 current_res;
  in_item_t               in_item;

  assign in_item  = samples.data;
  assign out_free = !out_valid || filtered.ready;

  tmf_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .out_free (out_free),
    .in_ready (in_ready),
    .ctrl     (ctrl)
  );

  assign samples.ready = in_ready;

  // Per-channel history lines
  tmf_history #(.W(SAMPLE_BITS)) u_open_hist (
    .clk    (clk),
    .rst    (rst),
    .shift  (ctrl.shift),
    .rotate (ctrl.rotate),
    .din    (in_item.open_sample[SAMPLE_BITS-1:0]),
    .tail   (open_tail)
  );

  tmf_history #(.W(SAMPLE_BITS)) u_close_hist (
    .clk    (clk),
    .rst    (rst),
    .shift  (ctrl.shift),
    .rotate (ctrl.rotate),
    .din    (in_item.close_sample[SAMPLE_BITS-1:0]),
    .tail   (close_tail)
  );

  tmf_history #(.W(SAMPLE_BITS)) u_current_hist (
    .clk    (clk),
    .rst    (rst),
    .shift  (ctrl.shift),
    .rotate (ctrl.rotate),
    .din    (in_item.current_sample[SAMPLE_BITS-1:0]),
    .tail   (current_tail)
  );

  // Per-channel min/max/sum units
  tmf_unit #(.W(SAMPLE_BITS)) u_open_unit (
    .clk    (clk),
    .ctrl   (ctrl),
    .value  (open_tail),
    .result (open_res)
  );

  tmf_unit #(.W(SAMPLE_BITS)) u_close_unit (
    .clk    (clk),
    .ctrl   (ctrl),
    .value  (close_tail),
    .result (close_res)
  );

  tmf_unit #(.W(SAMPLE_BITS)) u_current_unit (
    .clk    (clk),
    .ctrl   (ctrl),
    .value  (current_tail),
    .result (current_res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load) begin
      out_valid <= 1'b1;
    end else if (filtered.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      out_data.open_filtered    <= open_res;
      out_data.close_filtered   <= close_res;
      out_data.current_filtered <= current_res;
    end
  end

  assign filtered.valid = out_valid;
  assign filtered.data  = out_data;

  // The sequencer is busy right after an input transfer
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready |=> !samples.ready)
    else $error("input ready right after a transfer");

  // With the output register empty at the transfer, the result is loaded as soon
  // as the pass over the history ends and is then seen as valid
  a_latency: assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready && !filtered.valid |-> ##12 filtered.valid)
    else $error("result missing twelve cycles after input transfer");

  // A new result only appears while the input side is held off
  a_result_from_pass: assert property (@(posedge clk) disable iff (rst)
    $rose(filtered.valid) |-> $past(!samples.ready))
    else $error("result appeared without a pass over the history");
endmodule

@@ src/tmf_history.sv @@
// Module: one channel's sample history as a shift line that can also circulate.
module tmf_history #(
  parameter int W = 12
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         shift,
  input  logic         rotate,
  input  logic [W-1:0] din,
  output logic [W-1:0] tail
);
  import tmf_pkg::*;

  logic [W-1:0] hist [WINDOW];

  // Shift in a new sample, or circulate the oldest entry back to the front
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW; i++) hist[i] <= '0;
    end else if (shift || rotate) begin
      hist[0] <= shift ? din : hist[WINDOW-1];
      for (int i = 1; i < WINDOW; i++) hist[i] <= hist[i-1];
    end
  end

  assign tail = hist[WINDOW-1];
endmodule

@@ src/tmf_unit.sv @@
// Module: per-channel compare and add unit that walks the history for min, max and sum.
module tmf_unit #(
  parameter int W = 12
) (
  input  logic                       clk,
  input  tmf_pkg::seq_ctrl_t         ctrl,
  input  logic [W-1:0]               value,
  output logic [tmf_pkg::FIELD_BITS-1:0] result
);
  import tmf_pkg::*;

  logic [W-1:0]        lo;
  logic [W-1:0]        hi;
  logic [ACC_BITS-1:0] acc;
  logic [ACC_BITS-1:0] trimmed;

  // One entry per step: track extremes and accumulate
  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      if (ctrl.first) begin
        lo  <= value;
        hi  <= value;
        acc <= ACC_BITS'(value);
      end else begin
        if (value > hi) hi <= value;
        if (value < lo) lo <= value;
        acc <= acc + ACC_BITS'(value);
      end
    end
  end

  // Drop one min and one max, then average the remaining eight
  assign trimmed = acc - ACC_BITS'(lo) - ACC_BITS'(hi);
  assign result  = trimmed[TRIM_SHIFT +: FIELD_BITS];
endmodule

@@ src/tmf_seq.sv @@
// Module: sequencer that steps the units over the history and hands off to the output register.
module tmf_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               out_free,
  output logic               in_ready,
  output tmf_pkg::seq_ctrl_t ctrl
);
  import tmf_pkg::*;

  state_t              state;
  state_t              state_next;
  logic [CNT_BITS-1:0] cnt;
  logic [CNT_BITS-1:0] cnt_next;

  // State and pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (in_valid) state_next = ST_ACCUM;
      end
      ST_ACCUM: begin
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_BITS'(WINDOW - 1)) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
        cnt_next   = '0;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready    = 1'b0;
    ctrl        = '0;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        ctrl.shift = in_valid;
      end
      ST_ACCUM: begin
        ctrl.rotate = 1'b1;
        ctrl.step   = 1'b1;
        ctrl.first  = (cnt == '0);
      end
      ST_FINISH: begin
        ctrl.load = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end
endmodule

@@ tb/three_channel_trimmed_mean_filter_core_tb.sv @@
// Testbench: self-checking stimulus and prediction for the trimmed-mean filter core.
module three_channel_trimmed_mean_filter_core_tb;
  import tmf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef field_t window_t [WINDOW];

  localparam field_t FULL_SCALE = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tmf_stream_if #(.T(in_item_t))  samples_if ();
  tmf_stream_if #(.T(out_item_t)) filtered_if ();

  three_channel_trimmed_mean_filter_core uut (
    .clk      (clk),
    .rst      (rst),
    .samples  (samples_if.sink),
    .filtered (filtered_if.source)
  );

  // Predictor state: one ten-deep history per channel
  window_t open_hist;
  window_t close_hist;
  window_t current_hist;

  out_item_t filtered_expected [$];
  int        errors        = 0;
  int        samples_sent  = 0;
  int        results_seen  = 0;
  int        sender_idle_pct = 0;
  int        recv_stall_pct  = 0;
  int        hold_left       = 0;
  in_item_t  last_sample     = '0;

  // Clock
  always #1 clk = ~clk;

  // Mean of the middle eight: drop one copy of the minimum and the maximum
  function automatic field_t trimmed_mean(window_t h);
    field_t                lo;
    field_t                hi;
    logic [ACC_BITS-1:0]   acc;
    lo  = h[0];
    hi  = h[0];
    acc = '0;
    for (int k = 0; k < WINDOW; k++) begin
      if (h[k] < lo) lo = h[k];
      if (h[k] > hi) hi = h[k];
      acc = acc + ACC_BITS'(h[k]);
    end
    acc = acc - ACC_BITS'(lo) - ACC_BITS'(hi);
    return field_t'(acc >> TRIM_SHIFT);
  endfunction

  // Shift the new samples in and work out the filtered values
  function automatic out_item_t predict_filtered(in_item_t s);
    out_item_t r;
    for (int k = WINDOW - 1; k > 0; k--) begin
      open_hist[k]    = open_hist[k-1];
      close_hist[k]   = close_hist[k-1];
      current_hist[k] = current_hist[k-1];
    end
    open_hist[0]    = s.open_sample;
    close_hist[0]   = s.close_sample;
    current_hist[0] = s.current_sample;
    r.open_filtered    = trimmed_mean(open_hist);
    r.close_filtered   = trimmed_mean(close_hist);
    r.current_filtered = trimmed_mean(current_hist);
    return r;
  endfunction

  // Random sample: mostly full range or a slow drift, now and then a rail spike
  function automatic field_t wander(field_t prev);
    int pick;
    int v;
    pick = $urandom_range(9);
    if (pick < 5) begin
      v = $urandom_range(int'(FULL_SCALE));
    end else if (pick < 9) begin
      v = int'(prev) + $urandom_range(128) - 64;
      if (v < 0) v = 0;
      if (v > int'(FULL_SCALE)) v = int'(FULL_SCALE);
    end else begin
      v = $urandom_range(1) ? int'(FULL_SCALE) : 0;
    end
    return field_t'(v);
  endfunction

  function automatic in_item_t random_sample(in_item_t prev);
    in_item_t s;
    s.open_sample    = wander(prev.open_sample);
    s.close_sample   = wander(prev.close_sample);
    s.current_sample = wander(prev.current_sample);
    return s;
  endfunction

  // Offer one item, optionally after an idle gap; returns once it transfers
  task automatic push_samples(in_item_t s);
    int gap;
    gap = 0;
    while (sender_idle_pct > 0 && gap < 40 && $urandom_range(99) < sender_idle_pct)
      gap++;
    @(negedge clk);
    if (gap > 0) begin
      samples_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    samples_if.valid <= 1'b1;
    samples_if.data  <= s;
    do @(posedge clk); while (!samples_if.ready);
    filtered_expected.push_back(predict_filtered(s));
    samples_sent++;
    last_sample = s;
  endtask

  task automatic release_samples();
    @(negedge clk);
    samples_if.valid <= 1'b0;
  endtask

  task automatic wait_results_done();
    while (filtered_expected.size() != 0) @(posedge clk);
  endtask

  // Receiver: long hold-off when requested, otherwise random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      filtered_if.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      filtered_if.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst && filtered_if.valid && filtered_if.ready) begin
      got = filtered_if.data;
      results_seen++;
      if (filtered_expected.size() == 0) begin
        $error("result transfer with no expectation waiting: %0d %0d %0d",
               got.open_filtered, got.close_filtered, got.current_filtered);
        errors++;
      end else begin
        want = filtered_expected.pop_front();
        if (got.open_filtered !== want.open_filtered) begin
          $error("open_filtered: expected %0d, actual %0d",
                 want.open_filtered, got.open_filtered);
          errors++;
        end
        if (got.close_filtered !== want.close_filtered) begin
          $error("close_filtered: expected %0d, actual %0d",
                 want.close_filtered, got.close_filtered);
          errors++;
        end
        if (got.current_filtered !== want.current_filtered) begin
          $error("current_filtered: expected %0d, actual %0d",
                 want.current_filtered, got.current_filtered);
          errors++;
        end
      end
    end
  end

  // Start-up: histories full of zeros show up in the first nine results
  task automatic test_startup_fill();
    in_item_t s;
    s.open_sample    = FULL_SCALE;
    s.close_sample   = 12'h800;
    s.current_sample = 12'h001;
    repeat (WINDOW) push_samples(s);
  endtask

  // Rails, ties and single spikes
  task automatic test_extremes_and_ties();
    in_item_t s;
    // repeated equal entries: only one copy of min and max removed
    s = '{open_sample: 12'h000, close_sample: FULL_SCALE, current_sample: 12'h7ff};
    repeat (4) push_samples(s);
    // lone spike at each rail
    s = '{open_sample: FULL_SCALE, close_sample: 12'h000, current_sample: FULL_SCALE};
    push_samples(s);
    s = '{open_sample: 12'h000, close_sample: FULL_SCALE, current_sample: 12'h000};
    push_samples(s);
    push_samples(s);
    // alternating bit patterns
    s = '{open_sample: 12'haaa, close_sample: 12'h555, current_sample: 12'haaa};
    push_samples(s);
    s = '{open_sample: 12'h555, close_sample: 12'haaa, current_sample: 12'h555};
    push_samples(s);
    s = '{open_sample: 12'haaa, close_sample: 12'h555, current_sample: 12'h555};
    push_samples(s);
    s = '{open_sample: 12'h555, close_sample: 12'haaa, current_sample: 12'haaa};
    push_samples(s);
  endtask

  task automatic run_random(int count, int idle_pct, int stall_pct);
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    repeat (count) push_samples(random_sample(last_sample));
  endtask

  task automatic test_random_no_idle();
    run_random(250, 0, 0);
  endtask

  task automatic test_random_sender_idle();
    run_random(250, 72, 0);
  endtask

  task automatic test_random_receiver_stall();
    run_random(250, 0, 72);
  endtask

  task automatic test_random_both_idle();
    run_random(250, 38, 38);
  endtask

  // Receiver holds off long enough for the core to fill and stall its input
  task automatic test_output_backpressure();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    @(negedge clk);
    hold_left = 300;
    repeat (25) push_samples(random_sample(last_sample));
  endtask

  // Sender pauses until every result is back, then resumes
  task automatic test_drain_pause();
    run_random(20, 0, 38);
    release_samples();
    wait_results_done();
    run_random(20, 0, 38);
  endtask

  initial begin
    samples_if.valid  = 1'b0;
    samples_if.data   = '0;
    filtered_if.ready = 1'b0;
    for (int k = 0; k < WINDOW; k++) begin
      open_hist[k]    = '0;
      close_hist[k]   = '0;
      current_hist[k] = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_startup_fill();
    test_extremes_and_ties();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    test_output_backpressure();
    test_drain_pause();

    release_samples();
    recv_stall_pct = 0;
    wait_results_done();
    repeat (40) @(posedge clk);

    $display("Covered start-up fill, rails, ties, spikes and drifting random samples");
    $display("under back-pressure and idling: %0d samples in, %0d results checked",
             samples_sent, results_seen);
    if (errors == 0) begin
      $display("** three_channel_trimmed_mean_filter_core: PASSED **");
    end else begin
      $display("** three_channel_trimmed_mean_filter_core: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", filtered_expected.size());
    $display("** three_channel_trimmed_mean_filter_core: FAILED **");
    $finish;
  end

endmodule

@@ files.f @@
src/tmf_pkg.sv
src/tmf_stream_if.sv
src/tmf_history.sv
src/tmf_unit.sv
src/tmf_seq.sv
src/three_channel_trimmed_mean_filter_core.sv
tb/three_channel_trimmed_mean_filter_core_tb.sv
